// File: src/bli_pkg.sv
package bli_pkg;

   // Default table depth
   localparam int MAX_POINTS_DEF = 16;

   // Field widths
   localparam int IDX_W   = 4;
   localparam int TIME_W  = 32;
   localparam int VALUE_W = 32;

   // Request data layout, lowest bit first: point_index, time_req, point_value
   localparam int REQ_IDX_LSB   = 0;
   localparam int REQ_TIME_LSB  = REQ_IDX_LSB + IDX_W;
   localparam int REQ_VALUE_LSB = REQ_TIME_LSB + TIME_W;
   localparam int REQ_FIELDS_W  = REQ_VALUE_LSB + VALUE_W;
   localparam int REQ_DATA_W    = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W    = VALUE_W;

   // Action codes carried on req_tuser
   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   // Register file
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIODIC_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_POINTS_IN_USE = 1'd1;
   localparam logic [4:0] POINTS_IN_USE_RST = 5'd1;

   // Shared adder
   localparam int ALU_W = 65;

   typedef struct packed {
      logic             sub;
      logic [ALU_W-1:0] op_a;
      logic [ALU_W-1:0] op_b;
   } alu_req_type;

   // Iteration counts of the shared unit
   localparam int CNT_W = 7;
   localparam logic [CNT_W-1:0] MOD_STEPS      = 7'd32;
   localparam logic [CNT_W-1:0] DIV_STEPS_NARROW = 7'd16;
   localparam logic [CNT_W-1:0] DIV_STEPS_WIDE   = 7'd64;
   localparam logic [CNT_W-1:0] MUL_STEPS_NARROW = 7'd16;
   localparam logic [CNT_W-1:0] MUL_STEPS_WIDE   = 7'd48;

endpackage

// File: src/bli_table.sv
module bli_table #(
   parameter int DEPTH = bli_pkg::MAX_POINTS_DEF,
   parameter int AW    = bli_pkg::IDX_W
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_time,
   input  logic [31:0]   wr_value,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_time,
   output logic [31:0]   rd_value
);
   logic [31:0] time_mem  [DEPTH];
   logic [31:0] value_mem [DEPTH];
   logic [31:0] rd_time_ff;
   logic [31:0] rd_value_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[wr_addr]  <= wr_time;
         value_mem[wr_addr] <= wr_value;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   assign rd_time  = rd_time_ff;
   assign rd_value = rd_value_ff;

endmodule

// File: src/bli_alu.sv
module bli_alu (
   input  bli_pkg::alu_req_type           alu_req,
   output logic [bli_pkg::ALU_W-1:0]      alu_sum,
   output logic                           alu_carry
);
   import bli_pkg::*;

   logic [ALU_W:0] full;
   logic [ALU_W-1:0] op_b_eff;

   // Subtract as add of the complement; carry out set means op_a >= op_b
   assign op_b_eff  = alu_req.sub ? ~alu_req.op_b : alu_req.op_b;
   assign full      = {1'b0, alu_req.op_a} + {1'b0, op_b_eff} + {{ALU_W{1'b0}}, alu_req.sub};
   assign alu_sum   = full[ALU_W-1:0];
   assign alu_carry = full[ALU_W];

endmodule

// File: src/breakpoint_linear_interpolator_unit.sv
// Breakpoint table with linear interpolation between neighboring points.
// Request channel (req_*): req_tuser selects the action. A write beat stores
// (time, value) into a table slot and returns nothing; slots beyond the table
// depth are dropped. An evaluate beat gives a query time and returns exactly
// one rsp_* beat with the interpolated signed Q16.16 value.
// Register port (csr_*): periodic_mode and points_in_use; the user must write
// them only while the block is idle, which it does not enforce. A write lands
// at the clock edge where csr_we is high. One item at a time: req_tready is high
// only while the sequencer is idle. A write beat leaves the sequencer idle. An
// evaluate beat reads the first slot and, unless one point is in use, the last
// slot; periodic mode (last time above first) wraps the query by a remainder
// divide. A query at or beyond an end clamps to that end's value; else the slots
// are scanned (one read of the single table port per slot) and a bit-serial
// divide and multiply run on the shared 65-bit adder. The scan stops by the last
// slot in use at the latest, since the query then lies below the last time.
// The result sits in an output register, so a stalled receiver does not block
// the next request; only a second result waits until the first is taken.
// Reset (synchronous) clears the sequencer, the output valid and the
// registers (periodic_mode 0, points_in_use 1); table contents are kept.
module breakpoint_linear_interpolator_unit #(
   parameter int MAX_POINTS = bli_pkg::MAX_POINTS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // point_index[3:0], time_req[35:4], point_value[67:36], zero pad above
   input  logic [bli_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // curve_value[31:0]
   output logic [bli_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_we,
   input  logic [bli_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bli_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bli_pkg::*;

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [8:0] NMAX = 9'(MAX_POINTS);

   typedef enum logic [11:0] {
      ST_IDLE  = 12'b0000_0000_0001,
      ST_FIRST = 12'b0000_0000_0010,
      ST_LAST  = 12'b0000_0000_0100,
      ST_MOD   = 12'b0000_0000_1000,
      ST_WRAP  = 12'b0000_0001_0000,
      ST_CLAMP = 12'b0000_0010_0000,
      ST_SRCH  = 12'b0000_0100_0000,
      ST_SETUP = 12'b0000_1000_0000,
      ST_DIV   = 12'b0001_0000_0000,
      ST_MUL   = 12'b0010_0000_0000,
      ST_SUM   = 12'b0100_0000_0000,
      ST_DONE  = 12'b1000_0000_0000
   } state_type;

   // Control state
   state_type        state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             periodic_ff, periodic_in;
   logic [4:0]       pin_ff, pin_in;

   // Datapath state
   logic [31:0]      t_ff, t_in;
   logic [31:0]      first_t_ff, first_t_in, first_v_ff, first_v_in;
   logic [31:0]      last_t_ff, last_t_in, last_v_ff, last_v_in;
   logic [31:0]      lo_t_ff, lo_t_in, lo_v_ff, lo_v_in;
   logic [31:0]      hi_t_ff, hi_t_in, hi_v_ff, hi_v_in;
   logic [AW-1:0]    last_idx_ff, last_idx_in;
   logic             single_ff, single_in;
   logic [AW-1:0]    k_ff, k_in;
   logic [63:0]      rem_ff, rem_in, quo_ff, quo_in, div_d_ff, div_d_in;
   logic [47:0]      mcand_ff, mcand_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             neg_ff, neg_in;
   logic             wide_ff, wide_in;
   logic [31:0]      res_ff, res_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;

   // Request fields
   logic             req_accept;
   logic [IDX_W-1:0] req_idx;
   logic [31:0]      req_time, req_value;

   // Table port
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [31:0]      rd_time, rd_value;

   // Shared adder
   alu_req_type      alu_req;
   logic [ALU_W-1:0] alu_sum;
   logic             alu_carry;

   // Helpers
   logic [8:0]       pin_ext, n_eff, n_last, idx_ext;
   logic [32:0]      q_first, first_q, span33, d33, dv33, mag33;
   logic [31:0]      wrap_r;
   logic             div_ge;

   assign req_idx    = req_tdata[REQ_TIME_LSB-1:REQ_IDX_LSB];
   assign req_time   = req_tdata[REQ_VALUE_LSB-1:REQ_TIME_LSB];
   assign req_value  = req_tdata[REQ_FIELDS_W-1:REQ_VALUE_LSB];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Effective point count: zero counts as one, clip at the table depth
   always_comb begin
      pin_ext = {4'b0, pin_ff};
      if (pin_ff == 5'd0) begin
         n_eff = 9'd1;
      end else if (pin_ext > NMAX) begin
         n_eff = NMAX;
      end else begin
         n_eff = pin_ext;
      end
      n_last  = n_eff - 9'd1;
      idx_ext = {5'b0, req_idx};
   end

   // Drop writes to slots beyond the table depth
   assign wr_en   = req_accept && (req_tuser == ACTION_WRITE) && (idx_ext < NMAX);
   assign wr_addr = idx_ext[AW-1:0];

   // Read address; the table registers the read, so data arrives in the next cycle
   always_comb begin
      case (state_ff)
         ST_FIRST: rd_addr = last_idx_ff;
         ST_CLAMP: rd_addr = AW'(1);
         ST_SRCH:  rd_addr = k_ff + AW'(1);
         default:  rd_addr = '0;
      endcase
   end

   bli_table #(
      .DEPTH (MAX_POINTS),
      .AW    (AW)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_time  (req_time),
      .wr_value (req_value),
      .rd_addr  (rd_addr),
      .rd_time  (rd_time),
      .rd_value (rd_value)
   );

   // Operand selection for the shared adder
   always_comb begin
      alu_req.sub  = 1'b0;
      alu_req.op_a = '0;
      alu_req.op_b = '0;
      case (state_ff)
         ST_MOD, ST_DIV: begin
            // Restoring divide step: shift in next dividend bit, try subtract
            alu_req.sub  = 1'b1;
            alu_req.op_a = {rem_ff, quo_ff[63]};
            alu_req.op_b = {1'b0, div_d_ff};
         end
         ST_MUL: begin
            // Shift-add multiply, product kept modulo 2^48
            alu_req.op_a = {17'b0, rem_ff[47:0]};
            alu_req.op_b = quo_ff[0] ? {17'b0, mcand_ff} : '0;
         end
         ST_SUM: begin
            alu_req.sub  = neg_ff;
            alu_req.op_a = {{33{lo_v_ff[31]}}, lo_v_ff};
            alu_req.op_b = {33'b0, rem_ff[47:16]};
         end
         default: begin
            alu_req.sub = 1'b0;
         end
      endcase
   end

   bli_alu u_alu (
      .alu_req   (alu_req),
      .alu_sum   (alu_sum),
      .alu_carry (alu_carry)
   );

   assign div_ge  = alu_carry;
   assign q_first = {1'b0, t_ff} - {1'b0, first_t_ff};
   assign first_q = {1'b0, first_t_ff} - {1'b0, t_ff};
   assign span33  = {1'b0, hi_t_ff} - {1'b0, lo_t_ff};
   assign d33     = {1'b0, t_ff} - {1'b0, lo_t_ff};
   assign dv33    = {hi_v_ff[31], hi_v_ff} - {lo_v_ff[31], lo_v_ff};
   assign mag33   = dv33[32] ? (33'd0 - dv33) : dv33;
   assign wrap_r  = rem_ff[31:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      periodic_in  = periodic_ff;
      pin_in       = pin_ff;
      t_in         = t_ff;
      first_t_in   = first_t_ff;
      first_v_in   = first_v_ff;
      last_t_in    = last_t_ff;
      last_v_in    = last_v_ff;
      lo_t_in      = lo_t_ff;
      lo_v_in      = lo_v_ff;
      hi_t_in      = hi_t_ff;
      hi_v_in      = hi_v_ff;
      last_idx_in  = last_idx_ff;
      single_in    = single_ff;
      k_in         = k_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      div_d_in     = div_d_ff;
      mcand_in     = mcand_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      wide_in      = wide_ff;
      res_in       = res_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_PERIODIC_MODE: periodic_in = csr_wdata[0];
            CSR_POINTS_IN_USE: pin_in      = csr_wdata[4:0];
            default:           pin_in      = pin_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_tuser == ACTION_EVAL)) begin
               t_in        = req_time;
               last_idx_in = n_last[AW-1:0];
               single_in   = (n_eff == 9'd1);
               state_in    = ST_FIRST;
            end
         end
         ST_FIRST: begin
            first_t_in = rd_time;
            first_v_in = rd_value;
            if (single_ff) begin
               res_in   = rd_value;
               state_in = ST_DONE;
            end else begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            last_t_in = rd_time;
            last_v_in = rd_value;
            if (periodic_ff && (rd_time > first_t_ff)) begin
               // Floor modulo: divide |t - first| by the span, fix sign later
               neg_in   = q_first[32];
               rem_in   = '0;
               quo_in   = {(q_first[32] ? first_q[31:0] : q_first[31:0]), 32'b0};
               div_d_in = {32'b0, rd_time - first_t_ff};
               cnt_in   = MOD_STEPS;
               state_in = ST_MOD;
            end else begin
               state_in = ST_CLAMP;
            end
         end
         ST_MOD, ST_DIV: begin
            rem_in = div_ge ? alu_sum[63:0] : {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], div_ge};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == 7'd1) begin
               if (state_ff == ST_MOD) begin
                  state_in = ST_WRAP;
               end else begin
                  // Quotient now in quo; reuse rem as product accumulator
                  rem_in   = '0;
                  cnt_in   = wide_ff ? MUL_STEPS_WIDE : MUL_STEPS_NARROW;
                  state_in = ST_MUL;
               end
            end
         end
         ST_WRAP: begin
            if (neg_ff && (wrap_r != 32'd0)) begin
               t_in = last_t_ff - wrap_r;
            end else begin
               t_in = first_t_ff + wrap_r;
            end
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (t_ff <= first_t_ff) begin
               res_in   = first_v_ff;
               state_in = ST_DONE;
            end else if (t_ff >= last_t_ff) begin
               res_in   = last_v_ff;
               state_in = ST_DONE;
            end else begin
               lo_t_in  = first_t_ff;
               lo_v_in  = first_v_ff;
               k_in     = AW'(1);
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            // Upper point is the first slot whose time exceeds the query
            if (rd_time > t_ff) begin
               hi_t_in  = rd_time;
               hi_v_in  = rd_value;
               state_in = ST_SETUP;
            end else begin
               lo_t_in = rd_time;
               lo_v_in = rd_value;
               k_in    = k_ff + AW'(1);
            end
         end
         ST_SETUP: begin
            if (span33 == 33'd0) begin
               res_in   = lo_v_ff;
               state_in = ST_DONE;
            end else begin
               div_d_in = {{31{span33[32]}}, span33};
               neg_in   = dv33[32];
               mcand_in = {15'b0, mag33};
               if (!d33[32]) begin
                  // Offset below span: the fraction fits in 16 bits
                  wide_in = 1'b0;
                  rem_in  = {32'b0, d33[31:0]};
                  quo_in  = '0;
                  cnt_in  = DIV_STEPS_NARROW;
               end else begin
                  // Lower time above the query: 64-bit wrapped offset
                  wide_in = 1'b1;
                  rem_in  = '0;
                  quo_in  = {16'hFFFF, d33[31:0], 16'b0};
                  cnt_in  = DIV_STEPS_WIDE;
               end
               state_in = ST_DIV;
            end
         end
         ST_MUL: begin
            rem_in   = {16'b0, alu_sum[47:0]};
            mcand_in = {mcand_ff[46:0], 1'b0};
            quo_in   = {1'b0, quo_ff[63:1]};
            cnt_in   = cnt_ff - CNT_W'(1);
            if (cnt_ff == 7'd1) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            res_in   = alu_sum[31:0];
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Hold the result until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         periodic_ff  <= 1'b0;
         pin_ff       <= POINTS_IN_USE_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         periodic_ff  <= periodic_in;
         pin_ff       <= pin_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      t_ff        <= t_in;
      first_t_ff  <= first_t_in;
      first_v_ff  <= first_v_in;
      last_t_ff   <= last_t_in;
      last_v_ff   <= last_v_in;
      lo_t_ff     <= lo_t_in;
      lo_v_ff     <= lo_v_in;
      hi_t_ff     <= hi_t_in;
      hi_v_ff     <= hi_v_in;
      last_idx_ff <= last_idx_in;
      single_ff   <= single_in;
      k_ff        <= k_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_d_ff    <= div_d_in;
      mcand_ff    <= mcand_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      wide_ff     <= wide_in;
      res_ff      <= res_in;
   end

   // Partial remainder always stays below the divisor
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD || state_ff == ST_DIV) |-> (rem_ff < div_d_ff))
      else $error("partial remainder not below divisor");

   // A finished result waits while the output register is still occupied
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_DONE))
      else $error("result left DONE while output was stalled");

   // Output valid is raised only by the DONE state
   a_valid_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("output valid raised outside DONE");

   // A write beat starts no evaluation
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tuser == ACTION_WRITE) |=> (state_ff == ST_IDLE))
      else $error("write beat started the sequencer");

endmodule
